[src/e2bv_pkg.sv]
// Shared types and constants for the Euler-angle to basis-vector block.
// Holds the channel payload structs, fixed-point types and the CORDIC angle table.
// No dependencies.
package e2bv_pkg;

  localparam int FIELD_BITS   = 16;
  localparam int CORDIC_STEPS = 30;

  // CORDIC start value: the inverse gain in Q30.
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  // Quadrant codes taken from the top two bits of the turn.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Lanes of the sine/cosine pipeline.
  localparam int LANE_PITCH = 0;
  localparam int LANE_YAW   = 1;
  localparam int LANE_ROLL  = 2;
  localparam int LANES      = 3;

  typedef logic signed [31:0] cval_t;  // CORDIC x and y, Q30
  typedef logic signed [32:0] zval_t;  // residual angle, 2^32 units per turn
  typedef logic signed [33:0] qval_t;  // rounded Q30 products and sums
  typedef logic signed [63:0] prod_t;  // raw Q60 products

  // atan(2^-i) in units of 2^32 per full turn.
  localparam logic [31:0] ATAN_TURN32 [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef struct packed {
    logic [FIELD_BITS-1:0] pitch_angle;
    logic [FIELD_BITS-1:0] yaw_angle;
    logic [FIELD_BITS-1:0] roll_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] forward_x;
    logic signed [FIELD_BITS-1:0] forward_y;
    logic signed [FIELD_BITS-1:0] forward_z;
    logic signed [FIELD_BITS-1:0] right_x;
    logic signed [FIELD_BITS-1:0] right_y;
    logic signed [FIELD_BITS-1:0] right_z;
    logic signed [FIELD_BITS-1:0] up_x;
    logic signed [FIELD_BITS-1:0] up_y;
    logic signed [FIELD_BITS-1:0] up_z;
  } out_item_t;

  // Drop 30 fraction bits of a Q60 product, rounding half away from zero.
  function automatic qval_t round_q30(prod_t v);
    prod_t mag;
    mag = v[63] ? -v : v;
    mag = (mag + (prod_t'(1) <<< 29)) >>> 30;
    return v[63] ? qval_t'(-mag) : qval_t'(mag);
  endfunction

endpackage

[src/e2bv_if.sv]
// Valid/ready channel interfaces for the angle requests and the vector results.
// Depends on e2bv_pkg for the payload structs.
interface e2bv_in_if;
  logic                valid;
  logic                ready;
  e2bv_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface e2bv_out_if;
  logic                valid;
  logic                ready;
  e2bv_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/euler_to_basis_vectors_top.sv]
// Euler angles to forward, right and up basis vectors, fully pipelined.
// Depends on e2bv_pkg and the channel interfaces in e2bv_if.sv.
//
// Usage:
//  - in_if carries one request: pitch, yaw and roll as binary angles with
//    2^ANGLE_BITS units per turn. A request is taken when valid and ready are high.
//  - out_if carries the nine vector components in Q2.14 (at FRACTION_BITS = 14),
//    rounded half away from zero and saturated to plus or minus one.
//  - Between acceptance and out_if a request passes through one angle-prep stage,
//    30 CORDIC stages, a quadrant stage, two multiply and round pairs, a sum stage
//    and the output register.
//  - Throughput is one request per cycle unless out_if stalls. The rate is set by the
//    per-stage pipeline: each CORDIC iteration and each multiplier rank has its own register.
//  - Every stage carries a valid bit and holds when the stage after it is full
//    and held, so a stalled receiver fills the pipeline bubble by bubble. Input
//    ready stays high while any stage has room.
//  - Synchronous active-low reset empties the pipeline; no result is lost or
//    repeated across a stall.
module euler_to_basis_vectors_top #(
  parameter int ANGLE_BITS    = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  e2bv_in_if.sink           in_if,
  e2bv_out_if.source        out_if
);

  localparam int STEPS   = e2bv_pkg::CORDIC_STEPS;
  localparam int ST_PREP = 0;
  localparam int ST_QUAD = STEPS + 1;
  localparam int ST_M1   = STEPS + 2;
  localparam int ST_R1   = STEPS + 3;
  localparam int ST_M2   = STEPS + 4;
  localparam int ST_R2   = STEPS + 5;
  localparam int ST_SUM  = STEPS + 6;
  localparam int ST_OUT  = STEPS + 7;
  localparam int NST     = STEPS + 8;

  localparam int FIN_SHIFT = 30 - FRACTION_BITS;
  localparam e2bv_pkg::qval_t FIN_HALF =
    (FIN_SHIFT == 0) ? '0 : (e2bv_pkg::qval_t'(1) <<< (FIN_SHIFT - 1));
  localparam e2bv_pkg::qval_t FIN_ONE = e2bv_pkg::qval_t'(1) <<< FRACTION_BITS;
  localparam logic [31:0] ANGLE_MASK = (32'd1 << ANGLE_BITS) - 32'd1;

  // Round a Q30 value to the output fraction, saturate and keep 16 bits.
  function automatic logic [e2bv_pkg::FIELD_BITS-1:0] finish(e2bv_pkg::qval_t v);
    e2bv_pkg::qval_t mag;
    e2bv_pkg::qval_t res;
    mag = v[33] ? -v : v;
    mag = (mag + FIN_HALF) >>> FIN_SHIFT;
    if (mag > FIN_ONE) begin
      mag = FIN_ONE;
    end
    res = v[33] ? -mag : mag;
    return res[e2bv_pkg::FIELD_BITS-1:0];
  endfunction

  // Stage valid bits and the load enables that ripple back from the output.
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  assign en[NST-1] = !v_r[NST-1] || out_if.ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  assign in_if.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_if.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // CORDIC pipeline registers, stage 0 is the prepared angle.
  e2bv_pkg::cval_t cx_r [STEPS+1][e2bv_pkg::LANES];
  e2bv_pkg::cval_t cy_r [STEPS+1][e2bv_pkg::LANES];
  e2bv_pkg::zval_t cz_r [STEPS+1][e2bv_pkg::LANES];
  logic [1:0]      cq_r [STEPS+1][e2bv_pkg::LANES];

  logic [e2bv_pkg::FIELD_BITS-1:0] angle_in [e2bv_pkg::LANES];
  assign angle_in[e2bv_pkg::LANE_PITCH] = in_if.data.pitch_angle;
  assign angle_in[e2bv_pkg::LANE_YAW]   = in_if.data.yaw_angle;
  assign angle_in[e2bv_pkg::LANE_ROLL]  = in_if.data.roll_angle;

  // Angle prep: wrap to one turn, scale to 2^32 units, split off the quadrant.
  for (genvar l = 0; l < e2bv_pkg::LANES; l++) begin : g_prep
    logic [31:0] turn32;
    assign turn32 = (({{(32 - e2bv_pkg::FIELD_BITS){1'b0}}, angle_in[l]}) & ANGLE_MASK)
                    << (32 - ANGLE_BITS);
    always_ff @(posedge clk) begin
      if (en[ST_PREP]) begin
        cx_r[0][l] <= e2bv_pkg::CORDIC_GAIN_Q30;
        cy_r[0][l] <= '0;
        cz_r[0][l] <= e2bv_pkg::zval_t'({3'b000, turn32[29:0]});
        cq_r[0][l] <= turn32[31:30];
      end
    end
  end

  // One CORDIC rotation per stage, three lanes side by side.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    for (genvar l = 0; l < e2bv_pkg::LANES; l++) begin : g_lane
      e2bv_pkg::zval_t atan_z;
      assign atan_z = e2bv_pkg::zval_t'({1'b0, e2bv_pkg::ATAN_TURN32[i]});
      always_ff @(posedge clk) begin
        if (en[i+1]) begin
          if (!cz_r[i][l][32]) begin
            cx_r[i+1][l] <= cx_r[i][l] - (cy_r[i][l] >>> i);
            cy_r[i+1][l] <= cy_r[i][l] + (cx_r[i][l] >>> i);
            cz_r[i+1][l] <= cz_r[i][l] - atan_z;
          end else begin
            cx_r[i+1][l] <= cx_r[i][l] + (cy_r[i][l] >>> i);
            cy_r[i+1][l] <= cy_r[i][l] - (cx_r[i][l] >>> i);
            cz_r[i+1][l] <= cz_r[i][l] + atan_z;
          end
          cq_r[i+1][l] <= cq_r[i][l];
        end
      end
    end
  end

  // Quadrant fold: map the first-quadrant rotation back to the full turn.
  e2bv_pkg::cval_t sin_r [e2bv_pkg::LANES];
  e2bv_pkg::cval_t cos_r [e2bv_pkg::LANES];

  for (genvar l = 0; l < e2bv_pkg::LANES; l++) begin : g_quad
    e2bv_pkg::cval_t fx;
    e2bv_pkg::cval_t fy;
    assign fx = cx_r[STEPS][l];
    assign fy = cy_r[STEPS][l];
    always_ff @(posedge clk) begin
      if (en[ST_QUAD]) begin
        case (cq_r[STEPS][l])
          e2bv_pkg::QUAD_0: begin
            cos_r[l] <= fx;
            sin_r[l] <= fy;
          end
          e2bv_pkg::QUAD_1: begin
            cos_r[l] <= -fy;
            sin_r[l] <= fx;
          end
          e2bv_pkg::QUAD_2: begin
            cos_r[l] <= -fx;
            sin_r[l] <= -fy;
          end
          default: begin
            cos_r[l] <= fy;
            sin_r[l] <= -fx;
          end
        endcase
      end
    end
  end

  e2bv_pkg::cval_t sp, cp, sy, cy, sr, cr;
  assign sp = sin_r[e2bv_pkg::LANE_PITCH];
  assign cp = cos_r[e2bv_pkg::LANE_PITCH];
  assign sy = sin_r[e2bv_pkg::LANE_YAW];
  assign cy = cos_r[e2bv_pkg::LANE_YAW];
  assign sr = sin_r[e2bv_pkg::LANE_ROLL];
  assign cr = cos_r[e2bv_pkg::LANE_ROLL];

  // First multiplier rank: all pairwise products that the vectors need.
  e2bv_pkg::prod_t m1_srsp_r, m1_crsp_r, m1_cpcy_r, m1_cpsy_r, m1_srcp_r;
  e2bv_pkg::prod_t m1_crcp_r, m1_crsy_r, m1_crcy_r, m1_srsy_r, m1_srcy_r;
  e2bv_pkg::cval_t m1_sp_r, m1_sy_r, m1_cy_r;

  always_ff @(posedge clk) begin
    if (en[ST_M1]) begin
      m1_srsp_r <= e2bv_pkg::prod_t'(sr) * e2bv_pkg::prod_t'(sp);
      m1_crsp_r <= e2bv_pkg::prod_t'(cr) * e2bv_pkg::prod_t'(sp);
      m1_cpcy_r <= e2bv_pkg::prod_t'(cp) * e2bv_pkg::prod_t'(cy);
      m1_cpsy_r <= e2bv_pkg::prod_t'(cp) * e2bv_pkg::prod_t'(sy);
      m1_srcp_r <= e2bv_pkg::prod_t'(sr) * e2bv_pkg::prod_t'(cp);
      m1_crcp_r <= e2bv_pkg::prod_t'(cr) * e2bv_pkg::prod_t'(cp);
      m1_crsy_r <= e2bv_pkg::prod_t'(cr) * e2bv_pkg::prod_t'(sy);
      m1_crcy_r <= e2bv_pkg::prod_t'(cr) * e2bv_pkg::prod_t'(cy);
      m1_srsy_r <= e2bv_pkg::prod_t'(sr) * e2bv_pkg::prod_t'(sy);
      m1_srcy_r <= e2bv_pkg::prod_t'(sr) * e2bv_pkg::prod_t'(cy);
      m1_sp_r   <= sp;
      m1_sy_r   <= sy;
      m1_cy_r   <= cy;
    end
  end

  // Round the first rank back to Q30.
  e2bv_pkg::qval_t r1_srsp_r, r1_crsp_r, r1_cpcy_r, r1_cpsy_r, r1_srcp_r;
  e2bv_pkg::qval_t r1_crcp_r, r1_crsy_r, r1_crcy_r, r1_srsy_r, r1_srcy_r;
  e2bv_pkg::cval_t r1_sp_r, r1_sy_r, r1_cy_r;

  always_ff @(posedge clk) begin
    if (en[ST_R1]) begin
      r1_srsp_r <= e2bv_pkg::round_q30(m1_srsp_r);
      r1_crsp_r <= e2bv_pkg::round_q30(m1_crsp_r);
      r1_cpcy_r <= e2bv_pkg::round_q30(m1_cpcy_r);
      r1_cpsy_r <= e2bv_pkg::round_q30(m1_cpsy_r);
      r1_srcp_r <= e2bv_pkg::round_q30(m1_srcp_r);
      r1_crcp_r <= e2bv_pkg::round_q30(m1_crcp_r);
      r1_crsy_r <= e2bv_pkg::round_q30(m1_crsy_r);
      r1_crcy_r <= e2bv_pkg::round_q30(m1_crcy_r);
      r1_srsy_r <= e2bv_pkg::round_q30(m1_srsy_r);
      r1_srcy_r <= e2bv_pkg::round_q30(m1_srcy_r);
      r1_sp_r   <= m1_sp_r;
      r1_sy_r   <= m1_sy_r;
      r1_cy_r   <= m1_cy_r;
    end
  end

  // Second multiplier rank: roll-pitch terms times the yaw sine and cosine.
  e2bv_pkg::prod_t m2_a_r, m2_b_r, m2_c_r, m2_d_r;
  e2bv_pkg::qval_t m2_cpcy_r, m2_cpsy_r, m2_srcp_r, m2_crcp_r;
  e2bv_pkg::qval_t m2_crsy_r, m2_crcy_r, m2_srsy_r, m2_srcy_r;
  e2bv_pkg::cval_t m2_sp_r;

  always_ff @(posedge clk) begin
    if (en[ST_M2]) begin
      m2_a_r    <= e2bv_pkg::prod_t'(r1_srsp_r) * e2bv_pkg::prod_t'(r1_cy_r);
      m2_b_r    <= e2bv_pkg::prod_t'(r1_srsp_r) * e2bv_pkg::prod_t'(r1_sy_r);
      m2_c_r    <= e2bv_pkg::prod_t'(r1_crsp_r) * e2bv_pkg::prod_t'(r1_cy_r);
      m2_d_r    <= e2bv_pkg::prod_t'(r1_crsp_r) * e2bv_pkg::prod_t'(r1_sy_r);
      m2_cpcy_r <= r1_cpcy_r;
      m2_cpsy_r <= r1_cpsy_r;
      m2_srcp_r <= r1_srcp_r;
      m2_crcp_r <= r1_crcp_r;
      m2_crsy_r <= r1_crsy_r;
      m2_crcy_r <= r1_crcy_r;
      m2_srsy_r <= r1_srsy_r;
      m2_srcy_r <= r1_srcy_r;
      m2_sp_r   <= r1_sp_r;
    end
  end

  // Round the second rank.
  e2bv_pkg::qval_t r2_a_r, r2_b_r, r2_c_r, r2_d_r;
  e2bv_pkg::qval_t r2_cpcy_r, r2_cpsy_r, r2_srcp_r, r2_crcp_r;
  e2bv_pkg::qval_t r2_crsy_r, r2_crcy_r, r2_srsy_r, r2_srcy_r;
  e2bv_pkg::cval_t r2_sp_r;

  always_ff @(posedge clk) begin
    if (en[ST_R2]) begin
      r2_a_r    <= e2bv_pkg::round_q30(m2_a_r);
      r2_b_r    <= e2bv_pkg::round_q30(m2_b_r);
      r2_c_r    <= e2bv_pkg::round_q30(m2_c_r);
      r2_d_r    <= e2bv_pkg::round_q30(m2_d_r);
      r2_cpcy_r <= m2_cpcy_r;
      r2_cpsy_r <= m2_cpsy_r;
      r2_srcp_r <= m2_srcp_r;
      r2_crcp_r <= m2_crcp_r;
      r2_crsy_r <= m2_crsy_r;
      r2_crcy_r <= m2_crcy_r;
      r2_srsy_r <= m2_srsy_r;
      r2_srcy_r <= m2_srcy_r;
      r2_sp_r   <= m2_sp_r;
    end
  end

  // Combine the terms into the nine Q30 components.
  e2bv_pkg::qval_t s_fx_r, s_fy_r, s_fz_r, s_rx_r, s_ry_r, s_rz_r;
  e2bv_pkg::qval_t s_ux_r, s_uy_r, s_uz_r;

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      s_fx_r <= r2_cpcy_r;
      s_fy_r <= r2_cpsy_r;
      s_fz_r <= -e2bv_pkg::qval_t'(r2_sp_r);
      s_rx_r <= r2_crsy_r - r2_a_r;
      s_ry_r <= -r2_b_r - r2_crcy_r;
      s_rz_r <= -r2_srcp_r;
      s_ux_r <= r2_c_r + r2_srsy_r;
      s_uy_r <= r2_d_r - r2_srcy_r;
      s_uz_r <= r2_crcp_r;
    end
  end

  // Output register: final rounding and saturation.
  e2bv_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_r.forward_x <= finish(s_fx_r);
      out_r.forward_y <= finish(s_fy_r);
      out_r.forward_z <= finish(s_fz_r);
      out_r.right_x   <= finish(s_rx_r);
      out_r.right_y   <= finish(s_ry_r);
      out_r.right_z   <= finish(s_rz_r);
      out_r.up_x      <= finish(s_ux_r);
      out_r.up_y      <= finish(s_uy_r);
      out_r.up_z      <= finish(s_uz_r);
    end
  end

  assign out_if.valid = v_r[ST_OUT];
  assign out_if.data  = out_r;

  // The CORDIC must have driven the pitch lane's residual angle close to zero.
  a_cordic_converged: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STEPS] |-> (cz_r[STEPS][e2bv_pkg::LANE_PITCH] <= 33'sd1024 &&
                    cz_r[STEPS][e2bv_pkg::LANE_PITCH] >= -33'sd1024))
    else $error("CORDIC residual angle too large");

  // The up_z result component never leaves the range of plus or minus one.
  a_out_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && FRACTION_BITS <= 14) |->
      ($signed(out_if.data.up_z) <= $signed(FIN_ONE[15:0]) &&
       $signed(out_if.data.up_z) >= -$signed(FIN_ONE[15:0])))
    else $error("result component outside saturation range");

  // An empty first stage always takes a request.
  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    (!v_r[ST_PREP] || !v_r[ST_OUT] || out_if.ready) |-> in_if.ready ||
      (v_r[ST_PREP] && !en[ST_PREP + 1]))
    else $error("input ready low with room in the pipeline");

endmodule

[sim/tb.sv]
// Testbench for euler_to_basis_vectors_top: angle requests in, basis vectors out.
// Depends on e2bv_pkg, the channel interfaces in e2bv_if.sv and the block's RTL.
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY     = 38;
  localparam int IDLE_LIMIT  = 5000;
  localparam int FRAC        = 14;
  localparam int N_RANDOM    = 330;

  logic clk;
  logic rst_n;

  e2bv_in_if  in_if ();
  e2bv_out_if out_if ();

  euler_to_basis_vectors_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  e2bv_pkg::out_item_t vec_queue[$];
  int        mismatches;
  int        idle_cycles;
  bit        timed_out;
  bit        hold_off;
  int        hold_cycles;

  // CORDIC angle table in units of 2^32 per turn.
  longint atan_tab [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  // Rounding right shift, half away from zero.
  function automatic longint round_shift(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  // Sine and cosine in Q30 from a 16-bit binary angle.
  task automatic angle_sincos(input logic [15:0] ang, output longint s, output longint c);
    longint x, y, z, nx;
    logic [31:0] t32;
    t32 = {ang, 16'd0};
    x = 652032874;
    y = 0;
    z = longint'(t32[29:0]);
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
    end
    case (t32[31:30])
      e2bv_pkg::QUAD_0: begin c = x;  s = y;  end
      e2bv_pkg::QUAD_1: begin c = -y; s = x;  end
      e2bv_pkg::QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // Round a Q30 component to Q2.14 and saturate to plus or minus one.
  function automatic logic signed [15:0] to_q14(longint q);
    longint v;
    v = round_shift(q, 30 - FRAC);
    if (v > (1 << FRAC)) v = 1 << FRAC;
    if (v < -(1 << FRAC)) v = -(1 << FRAC);
    return v[15:0];
  endfunction

  // Basis vectors predicted for one request.
  task automatic predict_basis(input e2bv_pkg::in_item_t req,
                               output e2bv_pkg::out_item_t vec);
    longint sp, cp, sy, cy, sr, cr, srsp, crsp;
    angle_sincos(req.pitch_angle, sp, cp);
    angle_sincos(req.yaw_angle, sy, cy);
    angle_sincos(req.roll_angle, sr, cr);
    srsp = q30_mul(sr, sp);
    crsp = q30_mul(cr, sp);
    vec.forward_x = to_q14(q30_mul(cp, cy));
    vec.forward_y = to_q14(q30_mul(cp, sy));
    vec.forward_z = to_q14(-sp);
    vec.right_x   = to_q14(-q30_mul(srsp, cy) + q30_mul(cr, sy));
    vec.right_y   = to_q14(-q30_mul(srsp, sy) - q30_mul(cr, cy));
    vec.right_z   = to_q14(-q30_mul(sr, cp));
    vec.up_x      = to_q14(q30_mul(crsp, cy) + q30_mul(sr, sy));
    vec.up_y      = to_q14(q30_mul(crsp, sy) - q30_mul(sr, cy));
    vec.up_z      = to_q14(q30_mul(cr, cp));
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one request; valid drops only for a gap, so requests can follow back to back.
  task automatic send_request(input logic [15:0] p, input logic [15:0] y,
                              input logic [15:0] r, input bit gaps);
    e2bv_pkg::in_item_t  req;
    e2bv_pkg::out_item_t vec;
    int        gap;
    req = '{pitch_angle: p, yaw_angle: y, roll_angle: r};
    gap = gaps ? rand_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    predict_basis(req, vec);
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    vec_queue.push_back(vec);
    @(negedge clk);
  endtask

  // Receiver ready, with random stalls and an optional long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_off) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= hold_cycles + 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) < 75);
    end
  end

  // Check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    e2bv_pkg::out_item_t want;
    e2bv_pkg::out_item_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (vec_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = vec_queue.pop_front();
        if (want !== got) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("euler_to_basis_vectors_top regression: fail");
      $finish;
    end
  end

  // Stop sending and wait until every expected result has come back.
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (vec_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  // Extreme angles and the quadrant boundaries.
  task automatic test_directed();
    logic [15:0] pts [10] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                              16'h3FFF, 16'h7FFF, 16'h2000, 16'h0001, 16'h5555};
    for (int i = 0; i < 10; i++)
      send_request(pts[i], pts[(i + 3) % 10], pts[(i + 7) % 10], 1'b0);
    send_request(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_request(16'h4000, 16'h4000, 16'h4000, 1'b0);
    send_request(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
    wait_drain();
  endtask

  // Random angles with random gaps on both sides.
  task automatic test_random();
    for (int i = 0; i < N_RANDOM; i++)
      send_request(16'($urandom()), 16'($urandom()), 16'($urandom()),
                   (i % 100) > 20);
    wait_drain();
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    hold_cycles = 0;
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 60; i++)
          send_request(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0);
      end
      begin
        while (hold_cycles < 80) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    wait_drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    mismatches   = 0;
    idle_cycles  = 0;
    timed_out    = 1'b0;
    hold_off     = 1'b0;
    hold_cycles  = 0;
    clk          = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random();
    test_backpressure();

    if (mismatches == 0)
      $display("euler_to_basis_vectors_top regression: pass");
    else
      $display("euler_to_basis_vectors_top regression: fail");
    $finish;
  end

endmodule

[filelist.f]
src/e2bv_pkg.sv
src/e2bv_if.sv
src/euler_to_basis_vectors_top.sv
sim/tb.sv
